// ===== rtl/sifs_pkg.sv =====
// Shared types, constants and constant functions of the spectral index flux scale block.
package sifs_pkg;

  localparam int MAX_TERMS = 4;
  localparam int NUM_COEFF = 4;
  localparam int TERMS_LIM = (MAX_TERMS < NUM_COEFF) ? MAX_TERMS : NUM_COEFF;
  localparam int CIDX_W    = $clog2(NUM_COEFF);
  localparam int LOG_FRAC  = 28;
  localparam int EXP_FRAC  = 24;
  localparam int LMAG_W    = 30;

  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [31:0] ONE_Q16   = 32'h0001_0000;

  typedef enum logic [2:0] {
    CFG_REF_FREQ  = 3'd0,
    CFG_NUM_TERMS = 3'd1,
    CFG_COEFF0    = 3'd2,
    CFG_COEFF1    = 3'd3,
    CFG_COEFF2    = 3'd4,
    CFG_COEFF3    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic unit;
    logic zero;
  } tag_t;

  function automatic logic [2:0] eff_terms(input logic [2:0] nt);
    return (nt > 3'(TERMS_LIM)) ? 3'(TERMS_LIM) : nt;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    int i;
    x = v;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q2.30 value of 2^(2^-idx), built by repeated square roots.
  function automatic logic [31:0] exp_tab(input int idx);
    logic [63:0] t;
    int i;
    t = isqrt64(64'd1 << 61);
    for (i = 2; i <= EXP_FRAC; i++) begin
      if (i <= idx) begin
        t = isqrt64(t << 30);
      end
    end
    return t[31:0];
  endfunction

endpackage

// ===== rtl/sifs_log2.sv =====
// Two-lane pipelined base-2 logarithm of the channel and reference frequencies.
module sifs_log2 (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  sifs_pkg::tag_t  in_tag,
  input  logic [31:0]     freq,
  input  logic [31:0]     ref_freq,
  output logic            out_valid,
  output sifs_pkg::tag_t  out_tag,
  output logic [32:0]     log_v,
  output logic [32:0]     log_ref
);
  import sifs_pkg::*;

  localparam int N = LOG_FRAC;

  logic          vld [N+1];
  tag_t          tag [N+1];
  logic [4:0]    kv  [N+1];
  logic [4:0]    kr  [N+1];
  logic [31:0]   mv  [N+1];
  logic [31:0]   mr  [N+1];
  logic [N-1:0]  fv  [N+1];
  logic [N-1:0]  fr  [N+1];

  logic [31:0] ref_fix;
  logic [4:0]  lead_v;
  logic [4:0]  lead_r;

  function automatic logic [4:0] lead_one(input logic [31:0] x);
    logic [4:0] k;
    k = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        k = 5'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [32:0] sq_step(input logic [31:0] m);
    logic [63:0] p;
    p = 64'(m) * 64'(m);
    return p[63:31];
  endfunction

  always_comb begin
    ref_fix = (ref_freq == '0) ? 32'd1 : ref_freq;
    lead_v  = lead_one(freq);
    lead_r  = lead_one(ref_fix);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag[0] <= in_tag;
      kv[0]  <= lead_v;
      kr[0]  <= lead_r;
      mv[0]  <= freq << (5'd31 - lead_v);
      mr[0]  <= ref_fix << (5'd31 - lead_r);
      fv[0]  <= '0;
      fr[0]  <= '0;
    end
  end

  for (genvar j = 1; j <= N; j++) begin : g_sq
    logic [32:0] sv;
    logic [32:0] sr;

    always_comb begin
      sv = sq_step(mv[j-1]);
      sr = sq_step(mr[j-1]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (adv) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tag[j] <= tag[j-1];
        kv[j]  <= kv[j-1];
        kr[j]  <= kr[j-1];
        mv[j]  <= sv[32] ? sv[32:1] : sv[31:0];
        mr[j]  <= sr[32] ? sr[32:1] : sr[31:0];
        fv[j]  <= {fv[j-1][N-2:0], sv[32]};
        fr[j]  <= {fr[j-1][N-2:0], sr[32]};
      end
    end
  end

  assign out_valid = vld[N];
  assign out_tag   = tag[N];
  assign log_v     = {kv[N], fv[N]};
  assign log_ref   = {kr[N], fr[N]};

endmodule

// ===== rtl/sifs_horner.sv =====
// Pipelined log ratio scaling and Horner evaluation of the spectral index polynomial.
module sifs_horner (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      adv,
  input  logic                                      in_valid,
  input  sifs_pkg::tag_t                            in_tag,
  input  logic [32:0]                               log_v,
  input  logic [32:0]                               log_ref,
  input  logic [2:0]                                num_terms,
  input  logic [sifs_pkg::NUM_COEFF-1:0][31:0]      coeff,
  output logic                                      out_valid,
  output sifs_pkg::tag_t                            out_tag,
  output logic signed [30:0]                        expo
);
  import sifs_pkg::*;

  localparam logic signed [49:0] ACC_LIMIT = 50'sd1 << 40;
  localparam logic signed [49:0] EXP_LIMIT = 50'sd1 << 29;

  logic [2:0] nt_eff;
  assign nt_eff = eff_terms(num_terms);

  function automatic logic signed [49:0] clamp50(input logic signed [49:0] v,
                                                 input logic signed [49:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // First stage: signed difference of the two logarithms.
  logic signed [34:0] diff;
  logic        h0_vld, h1_vld;
  tag_t        h0_tag, h1_tag;
  logic        h0_neg, h1_neg;
  logic [32:0] h0_mag;
  logic [45:0] h1_ph;
  logic [46:0] h1_pl;

  assign diff = $signed({2'b00, log_v}) - $signed({2'b00, log_ref});

  always_ff @(posedge clk) begin
    if (rst) begin
      h0_vld <= 1'b0;
      h1_vld <= 1'b0;
    end else if (adv) begin
      h0_vld <= in_valid;
      h1_vld <= h0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h0_tag <= in_tag;
      h0_neg <= diff[34];
      h0_mag <= diff[34] ? 33'(-diff) : diff[32:0];
      h1_tag <= h0_tag;
      h1_neg <= h0_neg;
      h1_ph  <= 46'(h0_mag[32:17]) * 46'(LN2_Q30);
      h1_pl  <= 47'(h0_mag[16:0]) * 47'(LN2_Q30);
    end
  end

  // Third stage: round to Q.24 and load the highest coefficient.
  logic [63:0]        lsum;
  logic [2:0]         top_idx;
  logic signed [31:0] top_cf;

  always_comb begin
    lsum    = (64'(h1_ph) << 17) + 64'(h1_pl) + (64'd1 << 33);
    top_idx = nt_eff - 3'd1;
    top_cf  = $signed(coeff[top_idx[CIDX_W-1:0]]);
  end

  logic signed [47:0]  e_q    [NUM_COEFF+1];
  logic [LMAG_W-1:0]   lmag_q [NUM_COEFF+1];
  logic                lneg_q [NUM_COEFF+1];
  logic                vld_q  [NUM_COEFF+1];
  tag_t                tag_q  [NUM_COEFF+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= h1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_q[0]  <= h1_tag;
      lneg_q[0] <= h1_neg;
      lmag_q[0] <= lsum[34+LMAG_W-1:34];
      e_q[0]    <= (nt_eff == 3'd0) ? 48'sd0 : 48'(top_cf);
    end
  end

  // Each block multiplies by L in one stage and rounds, adds and clamps in the next.
  // The last block forms the negated exponent instead of adding a coefficient.
  for (genvar g = 0; g < NUM_COEFF; g++) begin : g_step
    logic [47:0]        eabs;
    logic [53:0]        pl;
    logic [46:0]        ph;
    logic               mneg;
    logic               mvld;
    tag_t               mtag;
    logic [LMAG_W-1:0]  mlmag;
    logic               mlneg;
    logic signed [47:0] mhold;
    logic [54:0]        plr;
    logic [47:0]        rr;
    logic signed [49:0] prod;
    logic signed [49:0] res;
    logic [2:0]         ci;
    logic signed [31:0] cf;
    logic               active;

    assign eabs = e_q[g][47] ? 48'(-e_q[g]) : e_q[g];

    always_ff @(posedge clk) begin
      if (rst) begin
        mvld <= 1'b0;
        vld_q[g+1] <= 1'b0;
      end else if (adv) begin
        mvld <= vld_q[g];
        vld_q[g+1] <= mvld;
      end
    end

    always_comb begin
      plr    = {1'b0, pl} + (55'd1 << 23);
      rr     = 48'(ph) + 48'(plr[54:24]);
      prod   = mneg ? -$signed({2'b00, rr}) : $signed({2'b00, rr});
      ci     = nt_eff - 3'(g + 2);
      cf     = $signed(coeff[ci[CIDX_W-1:0]]);
      if (g == NUM_COEFF - 1) begin
        active = 1'b1;
        res    = clamp50(-prod, EXP_LIMIT);
      end else begin
        active = (nt_eff > 3'(g + 1));
        res    = clamp50(prod + 50'(cf), ACC_LIMIT);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pl    <= 54'(eabs[23:0]) * 54'(lmag_q[g]);
        ph    <= 47'(eabs[40:24]) * 47'(lmag_q[g]);
        mneg  <= e_q[g][47] ^ lneg_q[g];
        mtag  <= tag_q[g];
        mlmag <= lmag_q[g];
        mlneg <= lneg_q[g];
        mhold <= e_q[g];
        tag_q[g+1]  <= mtag;
        lmag_q[g+1] <= mlmag;
        lneg_q[g+1] <= mlneg;
        e_q[g+1]    <= active ? res[47:0] : mhold;
      end
    end
  end

  assign out_valid = vld_q[NUM_COEFF];
  assign out_tag   = tag_q[NUM_COEFF];
  assign expo      = e_q[NUM_COEFF][30:0];

endmodule

// ===== rtl/sifs_exp2.sv =====
// Pipelined natural exponential in Q16.16 with saturation and the output register.
module sifs_exp2 (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  sifs_pkg::tag_t      in_tag,
  input  logic signed [30:0]  expo,
  output logic                out_valid,
  output logic [31:0]         scale,
  output logic                overflow
);
  import sifs_pkg::*;

  localparam int N = EXP_FRAC;

  // Conversion to base two.
  logic        e0_vld;
  tag_t        e0_tag;
  logic        e0_neg;
  logic [60:0] e0_prod;
  logic [29:0] xmag;

  assign xmag = expo[30] ? 30'(-expo) : expo[29:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      e0_vld <= 1'b0;
    end else if (adv) begin
      e0_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e0_tag  <= in_tag;
      e0_neg  <= expo[30];
      e0_prod <= 61'(xmag) * 61'(LOG2E_Q30);
    end
  end

  logic [60:0]        ysum;
  logic [31:0]        ymag;
  logic signed [31:0] yval;

  always_comb begin
    ysum = e0_prod + (61'd1 << 29);
    ymag = 32'(ysum[60:30]);
    yval = e0_neg ? -$signed(ymag) : $signed(ymag);
  end

  logic              vld [N+1];
  tag_t              tag [N+1];
  logic signed [7:0] nq  [N+1];
  logic [N-1:0]      fq  [N+1];
  logic [31:0]       rq  [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= e0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag[0] <= e0_tag;
      nq[0]  <= yval[31:24];
      fq[0]  <= yval[23:0];
      rq[0]  <= 32'd1 << 30;
    end
  end

  // One table factor per fraction bit, most significant first.
  for (genvar i = 1; i <= N; i++) begin : g_tab
    localparam logic [31:0] TV = exp_tab(i);
    logic [63:0] p;

    assign p = 64'(rq[i-1]) * 64'(TV) + (64'd1 << 29);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tag[i] <= tag[i-1];
        nq[i]  <= nq[i-1];
        fq[i]  <= fq[i-1];
        rq[i]  <= fq[i-1][N-i] ? p[61:30] : rq[i-1];
      end
    end
  end

  // Scale by 2^n into Q16.16, then apply the special cases.
  logic [31:0] val;
  logic        sat;
  logic [33:0] up;
  logic [6:0]  sh;
  logic [63:0] down;
  logic [31:0] res_val;
  logic        res_sat;

  always_comb begin
    up   = {2'b00, rq[N]} << ((nq[N] == 8'sd15) ? 1 : 0);
    sh   = 7'(8'sd14 - nq[N]);
    down = ({32'b0, rq[N]} + (64'd1 << (sh - 7'd1))) >> sh;
    if (nq[N] >= 8'sd16) begin
      val = '1;
      sat = 1'b1;
    end else if (nq[N] >= 8'sd14) begin
      sat = (up[33:32] != 2'b00);
      val = sat ? '1 : up[31:0];
    end else begin
      sat = 1'b0;
      val = down[31:0];
    end
    if (tag[N].unit) begin
      res_val = ONE_Q16;
      res_sat = 1'b0;
    end else if (tag[N].zero) begin
      res_val = '1;
      res_sat = 1'b1;
    end else begin
      res_val = val;
      res_sat = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scale    <= res_val;
      overflow <= res_sat;
    end
  end

endmodule

// ===== rtl/spectral_index_flux_scale.sv =====
// Top level of the spectral index flux scale block: configuration registers and pipeline.
//
// For each channel frequency v this block returns the flux scale factor
// (v/v0)^-(c0 + c1*L + c2*L^2 + c3*L^3) with L = ln(v/v0), as unsigned Q16.16.
// One request is accepted every clock cycle while the pipeline is not held;
// the logarithm has 28 squaring stages, the Horner chain four multiply and
// round pairs and the fractional power of two 24 table multiply stages. The
// whole pipeline holds while the output register is full and stalled, so
// nothing is lost or repeated. A zero frequency gives all ones with overflow
// set, unless the polynomial is empty or a single zero term, which always
// gives exactly 1.0. A result of 65536.0 or more saturates and sets overflow.
// A zero reference frequency acts as one hertz. Configuration writes are
// always ready and must only be made while no request is in flight.
module spectral_index_flux_scale (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] freq_hz,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] scale,
  output logic        overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sifs_pkg::*;

  logic [31:0]                 ref_freq_hz;
  logic [2:0]                  num_terms;
  logic [NUM_COEFF-1:0][31:0]  coeff;

  // The pipeline moves whenever the output register can take a new value.
  logic adv;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_freq_hz <= 32'd1;
      num_terms   <= '0;
      coeff       <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_REF_FREQ:  ref_freq_hz <= cfg_data;
        CFG_NUM_TERMS: num_terms   <= cfg_data[2:0];
        CFG_COEFF0:    coeff[0]    <= cfg_data;
        CFG_COEFF1:    coeff[1]    <= cfg_data;
        CFG_COEFF2:    coeff[2]    <= cfg_data;
        CFG_COEFF3:    coeff[3]    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The special cases are decided at entry and travel with the request.
  logic [2:0] nt_eff;
  tag_t       in_tag;

  always_comb begin
    nt_eff      = eff_terms(num_terms);
    in_tag.unit = (nt_eff == 3'd0) || ((nt_eff == 3'd1) && (coeff[0] == '0));
    in_tag.zero = (freq_hz == '0);
  end

  logic               lg_valid;
  tag_t               lg_tag;
  logic [32:0]        log_v;
  logic [32:0]        log_ref;
  logic               hn_valid;
  tag_t               hn_tag;
  logic signed [30:0] expo;

  sifs_log2 u_log2 (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_tag    (in_tag),
    .freq      (freq_hz),
    .ref_freq  (ref_freq_hz),
    .out_valid (lg_valid),
    .out_tag   (lg_tag),
    .log_v     (log_v),
    .log_ref   (log_ref)
  );

  sifs_horner u_horner (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (lg_valid),
    .in_tag    (lg_tag),
    .log_v     (log_v),
    .log_ref   (log_ref),
    .num_terms (num_terms),
    .coeff     (coeff),
    .out_valid (hn_valid),
    .out_tag   (hn_tag),
    .expo      (expo)
  );

  sifs_exp2 u_exp2 (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (hn_valid),
    .in_tag    (hn_tag),
    .expo      (expo),
    .out_valid (out_valid),
    .scale     (scale),
    .overflow  (overflow)
  );

endmodule

// ===== verif/spectral_index_flux_scale_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the spectral index flux scale block with its own fixed-point model.
module spectral_index_flux_scale_test;
  import sifs_pkg::*;

  // Register indexes past the end of the register list; writes to them are dropped.
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 100;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 48;

  localparam logic [63:0] LN2_FIX   = 64'd744261118;
  localparam logic [63:0] LOG2E_FIX = 64'd1549082005;
  localparam longint      ACC_SAT   = 64'sd1 <<< 40;
  localparam longint      EXP_SAT   = 64'sd1 <<< 29;
  localparam logic [31:0] UNITY     = 32'h0001_0000;
  localparam logic [31:0] SAT_SCALE = 32'hFFFF_FFFF;

  typedef struct {
    logic [31:0] scale;
    logic        overflow;
  } flux_t;

  // One line of the directed script: a register write or a frequency request.
  typedef struct {
    bit          is_write;
    logic [2:0]  index;
    logic [31:0] value;
    bit          known;
    logic [31:0] scale;
    logic        overflow;
  } script_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] freq_hz;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] scale;
  logic        overflow;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  spectral_index_flux_scale dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .freq_hz   (freq_hz),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .scale     (scale),
    .overflow  (overflow),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the configuration registers, updated on every accepted write.
  logic [31:0]        ref_freq_q;
  logic [2:0]         num_terms_q;
  logic signed [31:0] coeff_q [0:3];

  logic [63:0] root_two_tab [1:24];
  flux_t       pending_scales [$];
  script_row_t script [$];
  int          errors;
  int          cycles;
  bit          quiet;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Base-2 logarithm of a nonzero integer: leading-one position plus 28 fraction bits.
  function automatic logic [63:0] log2_fix(input logic [31:0] x);
    int          k;
    logic [63:0] m;
    logic [63:0] frac;
    k = 31;
    frac = '0;
    while (k > 0 && !x[k]) k--;
    m = {32'd0, x} << (31 - k);
    for (int i = 0; i < 28; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    return (64'(k) << 28) | frac;
  endfunction

  // Product of two Q.24 values, rounded half away from zero.
  function automatic longint mul_q24_round(input longint a, input longint b);
    bit          neg;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] low;
    logic [63:0] r;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = ua * (ub >> 16);
    q = ua * (ub & 64'hFFFF);
    low = ((p & 64'hFF) << 16) + q + (64'd1 << 23);
    r = (p >> 8) + (low >> 24);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // e^x for x in Q.24, as Q16.16 with saturation.
  function automatic flux_t exp_q16_16(input longint x_in);
    flux_t       res;
    longint      x;
    longint      y;
    logic [63:0] prod;
    logic [63:0] ymag;
    logic [63:0] yb;
    logic [63:0] r;
    logic [63:0] val;
    logic [23:0] f;
    int          n;
    int          s;
    x = clip(x_in, EXP_SAT);
    prod = ((x < 0) ? -x : x) * LOG2E_FIX;
    ymag = (prod + (64'd1 << 29)) >> 30;
    y = (x < 0) ? -longint'(ymag) : longint'(ymag);
    yb = y + (64'sd64 <<< 24);
    n = int'(yb >> 24) - 64;
    f = yb[23:0];
    r = 64'd1 << 30;
    for (int i = 1; i <= 24; i++) begin
      if (f[24 - i]) r = (r * root_two_tab[i] + (64'd1 << 29)) >> 30;
    end
    res.overflow = 1'b0;
    if (n >= 16) begin
      res.scale = SAT_SCALE;
      res.overflow = 1'b1;
      return res;
    end
    if (n >= 14) begin
      val = r << (n - 14);
    end else begin
      s = 14 - n;
      if (s > 62) begin
        res.scale = '0;
        return res;
      end
      val = (r + (64'd1 << (s - 1))) >> s;
    end
    if (val > 64'(SAT_SCALE)) begin
      res.scale = SAT_SCALE;
      res.overflow = 1'b1;
    end else begin
      res.scale = val[31:0];
    end
    return res;
  endfunction

  // Expected scale factor for one channel frequency under the shadow configuration.
  function automatic flux_t flux_scale_of(input logic [31:0] v);
    flux_t       res;
    logic [31:0] v0;
    int          nt;
    longint      d;
    longint      lval;
    longint      e;
    logic [63:0] dmag;
    logic [63:0] lmag;
    v0 = (ref_freq_q == 0) ? 32'd1 : ref_freq_q;
    nt = (num_terms_q > 3'd4) ? 4 : int'(num_terms_q);
    if (nt == 0 || (nt == 1 && coeff_q[0] == 0)) begin
      res.scale = UNITY;
      res.overflow = 1'b0;
      return res;
    end
    if (v == 0) begin
      res.scale = SAT_SCALE;
      res.overflow = 1'b1;
      return res;
    end
    d = longint'(log2_fix(v)) - longint'(log2_fix(v0));
    dmag = (d < 0) ? -d : d;
    lmag = (dmag * LN2_FIX + (64'd1 << 33)) >> 34;
    lval = (d < 0) ? -longint'(lmag) : longint'(lmag);
    e = longint'(coeff_q[nt - 1]);
    for (int i = nt - 2; i >= 0; i--) begin
      e = clip(mul_q24_round(e, lval) + longint'(coeff_q[i]), ACC_SAT);
    end
    return exp_q16_16(-mul_q24_round(e, lval));
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_REF_FREQ:  ref_freq_q = value;
      CFG_NUM_TERMS: num_terms_q = value[2:0];
      CFG_COEFF0:    coeff_q[0] = value;
      CFG_COEFF1:    coeff_q[1] = value;
      CFG_COEFF2:    coeff_q[2] = value;
      CFG_COEFF3:    coeff_q[3] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sends one frequency request; the expected result is either given or predicted.
  task automatic send_freq(input logic [31:0] f, input bit known, input logic [31:0] scl,
                           input logic ovf);
    int    gap;
    flux_t want;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    freq_hz  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (known) begin
      want.scale = scl;
      want.overflow = ovf;
    end else begin
      want = flux_scale_of(f);
    end
    pending_scales.push_back(want);
  endtask

  // Stops requests and waits until every result is back, so registers may change.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_scales.size() != 0) @(posedge clk);
  endtask

  task automatic add_write(input logic [2:0] index, input logic [31:0] value);
    script_row_t row;
    row = '{1'b1, index, value, 1'b0, 32'd0, 1'b0};
    script.push_back(row);
  endtask

  task automatic add_freq(input logic [31:0] f, input bit known, input logic [31:0] scl,
                          input logic ovf);
    script_row_t row;
    row = '{1'b0, 3'd0, f, known, scl, ovf};
    script.push_back(row);
  endtask

  // Random frequency: in nearly half of the cases near the reference, where the scale stays in range.
  function automatic logic [31:0] pick_freq();
    int          pick;
    logic [63:0] near;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      near = (64'(ref_freq_q) * $urandom_range(25, 400)) / 100;
      if (near == 0) near = 1;
      return (near > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : near[31:0];
    end
    if (pick < 75) return $urandom;
    if (pick < 90) return $urandom_range(1, 5000);
    case ($urandom_range(0, 2))
      0: return 32'd0;
      1: return 32'd1;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_coeff();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
    if (pick < 8) return $urandom;
    return 32'd0;
  endfunction

  function automatic logic [31:0] pick_ref();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 200000);
    endcase
  endfunction

  // Result checker: each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    flux_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_scales.size() == 0) begin
        $error("unexpected result: scale %h overflow %b", scale, overflow);
        errors++;
      end else begin
        want = pending_scales.pop_front();
        if (scale !== want.scale) begin
          $error("scale: expected %h, got %h", want.scale, scale);
          errors++;
        end
        if (overflow !== want.overflow) begin
          $error("overflow: expected %b, got %b", want.overflow, overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("spectral_index_flux_scale_test: errors");
      $finish;
    end
  end

  // The receiver stalls at random, with long stalls now and then, and not at all
  // while the quiet flag is set.
  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall <= 1'b0;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        hold = gap_len() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [63:0] t;
    script_row_t row;
    rst       = 1'b1;
    in_valid  = 1'b0;
    freq_hz   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors    = 0;
    cycles    = 0;
    quiet     = 1'b0;

    ref_freq_q  = 32'd1;
    num_terms_q = 3'd0;
    for (int i = 0; i < 4; i++) coeff_q[i] = '0;

    // Roots of two: entry i is 2^(2^-i) in Q2.30.
    t = floor_sqrt(64'd1 << 61);
    root_two_tab[1] = t;
    for (int i = 2; i <= 24; i++) begin
      t = floor_sqrt(t << 30);
      root_two_tab[i] = t;
    end

    // After reset the polynomial is empty, so every frequency, zero too, gives unity.
    add_freq(32'd0, 1, UNITY, 1'b0);
    add_freq(32'hFFFF_FFFF, 1, UNITY, 1'b0);
    // A single zero term also gives unity.
    add_write(CFG_NUM_TERMS, 32'd1);
    add_freq(32'd0, 1, UNITY, 1'b0);
    add_freq(32'd12345, 1, UNITY, 1'b0);
    // Spectral index 2.0 around 1 kHz.
    add_write(CFG_COEFF0, 32'h0200_0000);
    add_write(CFG_REF_FREQ, 32'd1000);
    add_freq(32'd0, 1, SAT_SCALE, 1'b1);
    add_freq(32'd1000, 1, UNITY, 1'b0);
    add_freq(32'd2000, 0, 32'd0, 1'b0);
    add_freq(32'd1, 0, 32'd0, 1'b0);
    add_freq(32'hFFFF_FFFF, 1, 32'd0, 1'b0);
    // Most negative index: far above the reference saturates, far below underflows.
    add_write(CFG_COEFF0, 32'h8000_0000);
    add_freq(32'hFFFF_FFFF, 1, SAT_SCALE, 1'b1);
    add_freq(32'd1, 1, 32'd0, 1'b0);
    // A zero reference acts as one hertz.
    add_write(CFG_REF_FREQ, 32'd0);
    add_write(CFG_COEFF0, 32'h7FFF_FFFF);
    add_freq(32'd1, 1, UNITY, 1'b0);
    add_freq(32'd2, 1, 32'd0, 1'b0);
    // Full cubic at the top reference.
    add_write(CFG_NUM_TERMS, 32'd4);
    add_write(CFG_COEFF0, 32'h0100_0000);
    add_write(CFG_COEFF1, 32'h0080_0000);
    add_write(CFG_COEFF2, 32'hFF00_0000);
    add_write(CFG_COEFF3, 32'h0010_0000);
    add_write(CFG_REF_FREQ, 32'hFFFF_FFFF);
    add_freq(32'd1, 0, 32'd0, 1'b0);
    add_freq(32'h8000_0000, 0, 32'd0, 1'b0);
    add_freq(32'hFFFF_FFFF, 1, UNITY, 1'b0);
    add_freq(32'd0, 1, SAT_SCALE, 1'b1);
    // Too many terms is cut back to four.
    add_write(CFG_NUM_TERMS, 32'd7);
    add_freq(32'h1234_5678, 0, 32'd0, 1'b0);
    // Writes to indexes past the list change nothing.
    add_write(CFG_SPARE_LO, 32'hFFFF_FFFF);
    add_write(CFG_SPARE_HI, 32'h0000_0001);
    add_freq(32'h0ABC_DEF0, 0, 32'd0, 1'b0);
    // Only the low bits of the term count are kept.
    add_write(CFG_NUM_TERMS, 32'hFFFF_FFF9);
    add_freq(32'h7FFF_FFFF, 0, 32'd0, 1'b0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      row = script[i];
      if (row.is_write) begin
        drain();
        write_reg(row.index, row.value);
      end else begin
        send_freq(row.value, row.known, row.scale, row.overflow);
      end
    end

    // Random phases: a fresh configuration each time, then a stream of requests.
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      quiet = ($urandom_range(0, 4) == 0);
      write_reg(CFG_REF_FREQ, pick_ref());
      write_reg(CFG_NUM_TERMS, $urandom_range(0, 7));
      write_reg(CFG_COEFF0, pick_coeff());
      write_reg(CFG_COEFF1, pick_coeff());
      write_reg(CFG_COEFF2, pick_coeff());
      write_reg(CFG_COEFF3, pick_coeff());
      for (int k = 0; k < PHASE_ITEMS; k++) send_freq(pick_freq(), 0, 32'd0, 1'b0);
    end

    drain();
    quiet = 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending_scales.size() == 0) begin
      $display("spectral_index_flux_scale_test: clean");
    end else begin
      $display("spectral_index_flux_scale_test: errors");
    end
    $finish;
  end

endmodule
